/* src/chained_hash_table_top_defines.svh */
// assertion macros for the chained hash table
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rst_n, prop, msg)
`define CHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* src/cht_pkg.sv */
`timescale 1ns / 1ps
package cht_pkg;
  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_ERASE  = 2'd2,
    FUNC_FIND_OR_INSERT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_RSVD   = 2'd3
  } status_e;

  localparam int unsigned SumW = 12;
endpackage

/* src/chained_hash_table_top.sv */
`timescale 1ns / 1ps
`include "chained_hash_table_top_defines.svh"
// Key/value hash table, WAYS slots per bucket, bucket = key byte sum modulo
// num_buckets (0 is taken as 1, values above BUCKETS as BUCKETS). After reset
// a clearing pass wipes the valid bits; items may be taken
// meanwhile but wait until it ends. The front takes an item and reduces the
// byte sum by eleven shift and subtract steps, one a cycle, then hands it
// through a one-entry queue to the back sequencer, which reads each way from
// the key and value RAMs in a read and a compare state and writes back. The
// front takes a new item once it has passed the last one on, so front and
// back can work on different items. Write the bucket count only while no
// item is in flight.
module chained_hash_table_top #(
  parameter int unsigned BUCKETS   = 256,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned KEY_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [10:0] entry_count_o
);
  localparam int unsigned BktW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic [8:0] num_buckets_q;
  logic fq_push, bq_valid_q, bq_pop;
  logic [1:0] f_func, bq_func_q;
  logic [31:0] f_key, f_value, bq_key_q, bq_value_q;
  logic [BktW-1:0] f_bkt, bq_bkt_q;

  // bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_buckets_q <= 9'd256;
    else if (cfg_we_i) num_buckets_q <= cfg_wdata_i;
  end

  cht_front #(.Buckets(BUCKETS), .KeyBytes(KEY_BYTES), .BktW(BktW)) u_front (
    .clk_i, .rst_ni, .num_buckets_q_i(num_buckets_q),
    .push_i(push), .full_o(full), .func_i, .key_i, .value_i,
    .fq_push_o(fq_push), .fq_full_i(bq_valid_q),
    .fq_func_o(f_func), .fq_key_o(f_key), .fq_value_o(f_value), .fq_bucket_o(f_bkt)
  );

  // one-entry queue between front and back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bq_valid_q <= 1'b0;
    else if (fq_push) bq_valid_q <= 1'b1;
    else if (bq_pop) bq_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (fq_push) begin
      bq_func_q <= f_func;
      bq_key_q <= f_key;
      bq_value_q <= f_value;
      bq_bkt_q <= f_bkt;
    end
  end

  cht_back #(.Buckets(BUCKETS), .Ways(WAYS), .BktW(BktW)) u_back (
    .clk_i, .rst_ni, .bq_valid_i(bq_valid_q), .bq_pop_o(bq_pop),
    .bq_func_i(bq_func_q), .bq_key_i(bq_key_q), .bq_value_i(bq_value_q),
    .bq_bucket_i(bq_bkt_q), .empty_o(empty), .pop_i(pop),
    .found_o, .read_value_o, .status_o, .entry_count_o
  );

  `CHT_ASSERT(a_top_q, clk_i, rst_ni, !(fq_push && bq_valid_q), "queue overrun")
endmodule

/* src/cht_ram.sv */
`timescale 1ns / 1ps
module cht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* src/cht_front.sv */
`timescale 1ns / 1ps
`include "chained_hash_table_top_defines.svh"
// front: byte sum then remainder by shift and subtract, one step a cycle
module cht_front #(
  parameter int unsigned Buckets  = 256,
  parameter int unsigned KeyBytes = 4,
  parameter int unsigned BktW     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [8:0]        num_buckets_q_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [1:0]        func_i,
  input  logic [31:0]       key_i,
  input  logic [31:0]       value_i,
  output logic              fq_push_o,
  input  logic              fq_full_i,
  output logic [1:0]        fq_func_o,
  output logic [31:0]       fq_key_o,
  output logic [31:0]       fq_value_o,
  output logic [BktW-1:0]   fq_bucket_o
);
  localparam int unsigned ModW = $clog2(Buckets + 1);
  localparam logic [ModW-1:0] BucketsC = ModW'(Buckets);
  localparam int unsigned NumSteps = cht_pkg::SumW - 1;
  localparam int unsigned CntW = $clog2(NumSteps + 1);
  localparam int unsigned ShW = cht_pkg::SumW + ModW;

  logic              busy_q, busy_d;
  logic [1:0]        func_q;
  logic [31:0]       key_q, value_q;
  logic [cht_pkg::SumW-1:0] rem_q, rem_d, sum;
  logic [ModW-1:0]   mod_q, nb_eff;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ShW-1:0]    mod_sh;

  // byte sum of the key
  always_comb begin
    sum = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (i < 4) sum = sum + cht_pkg::SumW'(key_i[8*(i%4) +: 8]);
    end
  end

  // effective modulus, clamped to one and to the bucket count
  always_comb begin
    if (num_buckets_q_i == 9'd0) nb_eff = ModW'(1);
    else if ({{(32-9){1'b0}}, num_buckets_q_i} > 32'(Buckets)) nb_eff = BucketsC;
    else nb_eff = ModW'(num_buckets_q_i);
  end

  logic rem_done;
  assign rem_done = cnt_q == '0;
  assign mod_sh   = ShW'(mod_q) << (cnt_q - CntW'(1));
  assign full_o   = busy_q;
  assign fq_push_o = busy_q && rem_done && !fq_full_i;
  assign fq_func_o = func_q;
  assign fq_key_o = key_q;
  assign fq_value_o = value_q;
  assign fq_bucket_o = BktW'(rem_q);

  // sum is below modulus times 2^NumSteps, so NumSteps steps leave the remainder
  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (!busy_q) begin
      if (push_i) begin
        busy_d = 1'b1;
        rem_d  = sum;
        cnt_d  = CntW'(NumSteps);
      end
    end else if (!rem_done) begin
      cnt_d = cnt_q - CntW'(1);
      if (ShW'(rem_q) >= mod_sh) rem_d = rem_q - cht_pkg::SumW'(mod_sh);
    end else if (!fq_full_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (!busy_q && push_i) begin
      func_q  <= func_i;
      key_q   <= key_i;
      value_q <= value_i;
      mod_q   <= nb_eff;
    end
  end

  `CHT_ASSERT(a_fr_rem_ok, clk_i, rst_ni, !fq_push_o || (rem_q < cht_pkg::SumW'(mod_q)), "bucket not reduced")
  `CHT_ASSERT(a_fr_mod_nz, clk_i, rst_ni, !busy_q || (mod_q != '0), "zero modulus")
  `CHT_ASSERT_NEXT(a_fr_take, clk_i, rst_ni, fq_push_o, !busy_q, "front did not release")
endmodule

/* src/cht_back.sv */
`timescale 1ns / 1ps
`include "chained_hash_table_top_defines.svh"
// back: scans ways of one bucket, one way at a time, then updates
module cht_back #(
  parameter int unsigned Buckets = 256,
  parameter int unsigned Ways    = 4,
  parameter int unsigned BktW    = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            bq_valid_i,
  output logic            bq_pop_o,
  input  logic [1:0]      bq_func_i,
  input  logic [31:0]     bq_key_i,
  input  logic [31:0]     bq_value_i,
  input  logic [BktW-1:0] bq_bucket_i,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            found_o,
  output logic [31:0]     read_value_o,
  output logic [1:0]      status_o,
  output logic [10:0]     entry_count_o
);
  localparam int unsigned Slots = Buckets * Ways;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned WayW  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned BktLast = Buckets - 1;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_READ = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_DONE = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [BktW-1:0]  clr_q;
  logic [WayW-1:0]  way_q;
  logic             hit_q, free_q;
  logic [WayW-1:0]  hit_way_q, free_way_q;
  logic [31:0]      hit_val_q;
  logic [1:0]       func_q;
  logic [31:0]      key_q, value_q;
  logic [BktW-1:0]  bkt_q;
  logic [10:0]      total_q;
  logic             out_found_q;
  logic [31:0]      out_val_q;
  logic [1:0]       out_status_q;

  logic [SlotW-1:0] rd_slot, wr_slot;
  logic [31:0]      rd_key, rd_val;
  logic             we;
  logic [31:0]      wr_val;
  logic             last_way;
  logic [Ways-1:0]  rd_vld, vld_wdata;
  logic             vld_we;
  logic [BktW-1:0]  vld_waddr;

  assign rd_slot  = SlotW'(32'(bkt_q) * Ways + 32'(way_q));
  assign last_way = 32'(way_q) == Ways - 1;

  cht_ram #(.Width(32), .Depth(Slots)) u_key_ram (
    .clk_i, .we_i(we), .waddr_i(wr_slot), .wdata_i(key_q),
    .raddr_i(rd_slot), .rdata_o(rd_key)
  );
  cht_ram #(.Width(32), .Depth(Slots)) u_val_ram (
    .clk_i, .we_i(we), .waddr_i(wr_slot), .wdata_i(wr_val),
    .raddr_i(rd_slot), .rdata_o(rd_val)
  );

  // valid bits, one word per bucket, read for the whole scan
  cht_ram #(.Width(Ways), .Depth(Buckets)) u_vld_ram (
    .clk_i, .we_i(vld_we), .waddr_i(vld_waddr), .wdata_i(vld_wdata),
    .raddr_i(bkt_q), .rdata_o(rd_vld)
  );

  // decide the outcome once all ways are seen
  logic do_ins, do_del;
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    if (state_q == ST_DONE) begin
      if (hit_q) do_del = func_q == cht_pkg::FUNC_ERASE;
      else if ((func_q == cht_pkg::FUNC_INSERT ||
                func_q == cht_pkg::FUNC_FIND_OR_INSERT) && free_q) do_ins = 1'b1;
    end
  end
  assign we      = do_ins;
  assign wr_slot = SlotW'(32'(bkt_q) * Ways + 32'(do_ins ? free_way_q : hit_way_q));
  assign wr_val  = (func_q == cht_pkg::FUNC_INSERT) ? value_q : 32'd0;

  // valid word write back, or zero during the clearing pass
  always_comb begin
    vld_wdata = rd_vld;
    if (do_ins) vld_wdata[free_way_q] = 1'b1;
    if (do_del) vld_wdata[hit_way_q] = 1'b0;
    if (state_q == ST_CLR) vld_wdata = '0;
  end
  assign vld_we    = (state_q == ST_CLR) || do_ins || do_del;
  assign vld_waddr = (state_q == ST_CLR) ? clr_q : bkt_q;

  assign bq_pop_o = state_q == ST_IDLE && bq_valid_i;
  assign empty_o  = state_q != ST_OUT;
  assign found_o  = out_found_q;
  assign read_value_o = out_val_q;
  assign status_o = out_status_q;
  assign entry_count_o = total_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (clr_q == BktW'(BktLast)) state_d = ST_IDLE;
      ST_IDLE: if (bq_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_CMP;
      ST_CMP:  state_d = last_way ? ST_DONE : ST_READ;
      ST_DONE: state_d = ST_OUT;
      ST_OUT:  if (pop_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + BktW'(1);
      if (do_ins) begin
        total_q <= total_q + 11'd1;
      end else if (do_del) begin
        total_q <= total_q - 11'd1;
      end
    end
  end

  // scan and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        func_q <= bq_func_i;
        key_q <= bq_key_i;
        value_q <= bq_value_i;
        bkt_q <= bq_bucket_i;
        way_q <= '0;
        hit_q <= 1'b0;
        free_q <= 1'b0;
      end
      ST_CMP: begin
        if (rd_vld[way_q]) begin
          if (!hit_q && rd_key == key_q) begin
            hit_q <= 1'b1;
            hit_way_q <= way_q;
            hit_val_q <= rd_val;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
          free_way_q <= way_q;
        end
        if (!last_way) way_q <= way_q + WayW'(1);
      end
      ST_DONE: begin
        out_found_q <= hit_q;
        if (hit_q) begin
          out_val_q <= hit_val_q;
          out_status_q <= cht_pkg::STATUS_OK;
        end else if (func_q == cht_pkg::FUNC_FIND || func_q == cht_pkg::FUNC_ERASE) begin
          out_val_q <= 32'd0;
          out_status_q <= cht_pkg::STATUS_ABSENT;
        end else if (!free_q) begin
          out_val_q <= 32'd0;
          out_status_q <= cht_pkg::STATUS_FULL;
        end else begin
          out_val_q <= wr_val;
          out_status_q <= cht_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  `CHT_ASSERT(a_bk_one_op, clk_i, rst_ni, !(do_ins && do_del), "insert and erase together")
  `CHT_ASSERT_NEXT(a_bk_out, clk_i, rst_ni, state_q == ST_DONE, !empty_o, "result not shown")
  `CHT_ASSERT(a_bk_status, clk_i, rst_ni, empty_o || status_o != cht_pkg::STATUS_RSVD, "bad status")
endmodule
